// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. The using module provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/wcg_pkg.sv -----
// ----------------------------------------------------------------------------
// wcg_pkg
// Types, constants and tables of the window coefficient generator.
// ----------------------------------------------------------------------------
package wcg_pkg;

  localparam int unsigned MAX_LEN = 4096;
  localparam int LEN_W  = 13;
  localparam int IDX_W  = 12;
  localparam int TYPE_W = 3;
  localparam int CFG_W  = 13;

  // window type codes
  localparam logic [TYPE_W-1:0] WT_RECT     = 3'd0;
  localparam logic [TYPE_W-1:0] WT_HANN     = 3'd1;
  localparam logic [TYPE_W-1:0] WT_HAMMING  = 3'd2;
  localparam logic [TYPE_W-1:0] WT_BLACKMAN = 3'd3;
  localparam logic [TYPE_W-1:0] WT_BARTLETT = 3'd4;
  localparam logic [TYPE_W-1:0] WT_FLATTOP  = 3'd5;

  // register indexes
  localparam logic REG_TYPE   = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  localparam logic [LEN_W-1:0]  RST_LENGTH = 13'd1024;
  localparam logic [TYPE_W-1:0] RST_TYPE   = WT_HANN;

  // Q30 constants
  localparam logic [31:0] Q30_ONE = 32'd1073741824;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [31:0] K_HALF  = 32'd536870912;
  localparam logic [31:0] K_054   = 32'd579820585;
  localparam logic [31:0] K_046   = 32'd493921239;
  localparam logic [31:0] K_042   = 32'd450971566;
  localparam logic [31:0] K_008   = 32'd85899346;
  localparam logic [31:0] K_193   = 32'd2072321720;
  localparam logic [31:0] K_129   = 32'd1385126953;
  localparam logic [31:0] K_0388  = 32'd416611828;
  localparam logic [31:0] K_0028  = 32'd30064771;

  // reciprocals: floor(t/c) == (t*M) >> S for t < 2^31
  localparam logic [31:0] RCP_56 = 32'd2454267027;
  localparam logic [31:0] RCP_30 = 32'd2290649225;
  localparam logic [31:0] RCP_12 = 32'd2863311531;
  localparam logic [31:0] RCP_72 = 32'd3817748708;
  localparam logic [31:0] RCP_42 = 32'd3272356036;
  localparam logic [31:0] RCP_20 = 32'd3435973837;
  localparam logic [31:0] RCP_6  = 32'd2863311531;

  typedef struct packed {
    logic restart;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] coefficient;
    logic [IDX_W-1:0]   sample_index;
    logic               last;
    logic [15:0]        rms_power;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  k;
    logic [31:0] kc;
    logic        neg;
    logic        full;   // divide the turn by L instead of L-1
  } term_t;

  typedef enum logic [2:0] {A_V, A_X, A_X2, A_H, A_K} a_sel_t;
  typedef enum logic [1:0] {B_CONST, B_X, B_H, B_MAG} b_sel_t;
  typedef enum logic [2:0] {WB_X, WB_X2, WB_HSUB, WB_H, WB_C, WB_S, WB_ACC} wb_t;

  typedef struct packed {
    a_sel_t      a;
    b_sel_t      b;
    wb_t         wb;
    logic [31:0] kc;
    logic [5:0]  sh;
  } uop_t;

  localparam logic [4:0] UOP_LAST = 5'd16;

  function automatic logic [2:0] term_count(logic [TYPE_W-1:0] wt);
    logic [2:0] c;
    c = 3'd0;
    case (wt)
      WT_HANN, WT_HAMMING: c = 3'd1;
      WT_BLACKMAN:         c = 3'd2;
      WT_FLATTOP:          c = 3'd4;
      default:             c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] base_q30(logic [TYPE_W-1:0] wt);
    logic [31:0] b;
    b = Q30_ONE;
    case (wt)
      WT_HANN:     b = K_HALF;
      WT_HAMMING:  b = K_054;
      WT_BLACKMAN: b = K_042;
      WT_BARTLETT: b = 32'd0;
      default:     b = Q30_ONE;
    endcase
    return b;
  endfunction

  function automatic term_t term_info(logic [TYPE_W-1:0] wt, logic [1:0] idx);
    term_t t;
    t = '{k: 3'd1, kc: K_HALF, neg: 1'b1, full: 1'b0};
    case (wt)
      WT_HAMMING: t.kc = K_046;
      WT_BLACKMAN: begin
        t.full = 1'b1;
        if (idx != 2'd0) begin
          t.k   = 3'd2;
          t.kc  = K_008;
          t.neg = 1'b0;
        end
      end
      WT_FLATTOP: begin
        unique case (idx)
          2'd0: t = '{k: 3'd1, kc: K_193,  neg: 1'b1, full: 1'b0};
          2'd1: t = '{k: 3'd2, kc: K_129,  neg: 1'b0, full: 1'b0};
          2'd2: t = '{k: 3'd3, kc: K_0388, neg: 1'b1, full: 1'b0};
          default: t = '{k: 3'd4, kc: K_0028, neg: 1'b0, full: 1'b0};
        endcase
      end
      default: t.kc = K_HALF;
    endcase
    return t;
  endfunction

  // cosine/sine Horner program and the final constant product
  function automatic uop_t wcg_uop(logic [4:0] step);
    uop_t u;
    u = '{a: A_X2, b: B_H, wb: WB_H, kc: 32'd0, sh: 6'd0};
    case (step)
      5'd0:  u = '{a: A_V,  b: B_CONST, wb: WB_X,    kc: PI_Q30, sh: 6'd0};
      5'd1:  u = '{a: A_X,  b: B_X,     wb: WB_X2,   kc: 32'd0,  sh: 6'd0};
      5'd2:  u = '{a: A_X2, b: B_CONST, wb: WB_HSUB, kc: RCP_56, sh: 6'd37};
      5'd4:  u = '{a: A_H,  b: B_CONST, wb: WB_HSUB, kc: RCP_30, sh: 6'd36};
      5'd6:  u = '{a: A_H,  b: B_CONST, wb: WB_HSUB, kc: RCP_12, sh: 6'd35};
      5'd7:  u = '{a: A_X2, b: B_H,     wb: WB_C,    kc: 32'd0,  sh: 6'd0};
      5'd8:  u = '{a: A_X2, b: B_CONST, wb: WB_HSUB, kc: RCP_72, sh: 6'd38};
      5'd10: u = '{a: A_H,  b: B_CONST, wb: WB_HSUB, kc: RCP_42, sh: 6'd37};
      5'd12: u = '{a: A_H,  b: B_CONST, wb: WB_HSUB, kc: RCP_20, sh: 6'd36};
      5'd14: u = '{a: A_H,  b: B_CONST, wb: WB_HSUB, kc: RCP_6,  sh: 6'd34};
      5'd15: u = '{a: A_X,  b: B_H,     wb: WB_S,    kc: 32'd0,  sh: 6'd0};
      5'd16: u = '{a: A_K,  b: B_MAG,   wb: WB_ACC,  kc: 32'd0,  sh: 6'd0};
      default: u = '{a: A_X2, b: B_H, wb: WB_H, kc: 32'd0, sh: 6'd0};
    endcase
    return u;
  endfunction

endpackage

// ----- sv/wcg_stream_if.sv -----
// ----------------------------------------------------------------------------
// wcg_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface wcg_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/window_coefficient_generator.sv -----
// ----------------------------------------------------------------------------
// window_coefficient_generator
// Window coefficient generator with a shared multiplier and serial divider.
// ----------------------------------------------------------------------------
// in_word  : valid/ready, data.restart. Each accepted word yields one out word.
// out_word : valid/ready, coefficient (Q3.12), sample_index, last, rms_power
//            (Q3.13, nonzero only on the last word of a window).
// cfg      : cfg_we/cfg_index/cfg_wdata; index 0 window type, 1 window length.
//            Write only while idle.
// One word is in work at a time; in_word.ready is high only when idle.
// Per cosine term: one 47-step radix-2 division of k*n*2^32 by the length,
// then 17 multiply/writeback pairs on the one 32x32 multiplier.
// The RMS uses the same divider, then a 23-step square root.
// A finished word waits in the output register; the next word can be taken
// while it waits, and computation stalls only before overwriting it.
// Reset (synchronous, rst_n low): type hann, length 1024, index and sum zero,
// no output pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module window_coefficient_generator (
  input  logic                       clk,
  input  logic                       rst_n,
  wcg_stream_if.sink                 in_word,
  wcg_stream_if.source               out_word,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [wcg_pkg::CFG_W-1:0]  cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_DIV, S_SQRT, S_MUL, S_WB, S_ROUND, S_SQ, S_SUM, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_COS, PH_BART, PH_RMS} phase_t;

  state_t                          state_r;
  phase_t                          phase_r;
  logic [wcg_pkg::TYPE_W-1:0]      type_r;
  logic [wcg_pkg::LEN_W-1:0]       length_r;
  logic [wcg_pkg::LEN_W-1:0]       len_r;
  logic [wcg_pkg::IDX_W-1:0]       d1_r;
  logic [wcg_pkg::IDX_W-1:0]       n_r;
  logic [wcg_pkg::IDX_W-1:0]       next_index_r;
  logic [43:0]                     sum_r;
  logic [2:0]                      term_r;
  logic [4:0]                      step_r;
  logic [5:0]                      cnt_r;
  logic [46:0]                     num_r;
  logic [46:0]                     quot_r;
  logic [24:0]                     rem_r;
  logic [wcg_pkg::LEN_W-1:0]       dvs_r;
  logic [1:0]                      quad_r;
  logic                            up_r;
  logic [29:0]                     v_r;
  logic [29:0]                     x_r;
  logic [29:0]                     x2_r;
  logic [30:0]                     h_r;
  logic [30:0]                     c_r;
  logic [63:0]                     p_r;
  logic signed [35:0]              acc_r;
  logic signed [15:0]              coef_r;
  logic                            last_r;
  logic [15:0]                     rms_r;
  logic                            out_valid_r;
  wcg_pkg::out_word_t              out_data_r;

  logic [wcg_pkg::LEN_W-1:0]       len_clamp;
  logic [wcg_pkg::IDX_W-1:0]       n_start;
  wcg_pkg::term_t                  ti;
  wcg_pkg::uop_t                   uop;
  logic [14:0]                     kn;
  logic [46:0]                     cos_num;
  logic [wcg_pkg::LEN_W-1:0]       cos_dvs;
  logic signed [13:0]              bt;
  logic [13:0]                     bmag;
  logic [11:0]                     bnum;
  logic [46:0]                     bart_num;
  logic [43:0]                     sum_nxt;
  logic [46:0]                     rms_num;
  logic [13:0]                     rs_d;
  logic                            ge_d;
  logic [13:0]                     rd_d;
  logic [26:0]                     rs_s;
  logic [26:0]                     trial;
  logic                            ge_s;
  logic [26:0]                     rd_s;
  logic [23:0]                     root_rnd;
  logic [15:0]                     rms_sat;
  logic [29:0]                     v_nxt;
  logic [30:0]                     mag;
  logic                            neg_cos;
  logic [31:0]                     mul_a;
  logic [31:0]                     mul_b;
  logic [63:0]                     p_shr;
  logic [63:0]                     p_rnd;
  logic [35:0]                     acc_mag;
  logic [35:0]                     q_sum;
  logic [17:0]                     q12;
  logic signed [15:0]              coef_nxt;
  logic [16:0]                     coef_mag;
  logic                            out_free;

  always_comb begin
    len_clamp = length_r;
    if (length_r < 13'd2) len_clamp = 13'd2;
    else if (length_r > wcg_pkg::LEN_W'(wcg_pkg::MAX_LEN)) begin
      len_clamp = wcg_pkg::LEN_W'(wcg_pkg::MAX_LEN);
    end
    n_start = (in_word.data.restart || ({1'b0, next_index_r} >= len_clamp)) ?
              '0 : next_index_r;

    ti      = wcg_pkg::term_info(type_r, term_r[1:0]);
    uop     = wcg_pkg::wcg_uop(step_r);
    kn      = 15'(ti.k) * 15'(n_r);
    cos_num = {kn, 32'd0};
    cos_dvs = ti.full ? len_r : {1'b0, d1_r};

    bt       = $signed({1'b0, n_r, 1'b0}) - $signed({2'b00, d1_r});
    bmag     = bt[13] ? 14'(-bt) : 14'(bt);
    bnum     = d1_r - bmag[11:0];
    bart_num = {5'd0, bnum, 30'd0} + 47'(d1_r >> 1);

    sum_nxt = ((n_r == '0) ? 44'd0 : sum_r) + {12'd0, p_r[31:0]};
    rms_num = {1'b0, sum_nxt, 2'b00} + 47'(len_r >> 1);

    // divider step
    rs_d = {rem_r[12:0], num_r[46]};
    ge_d = rs_d >= {1'b0, dvs_r};
    rd_d = ge_d ? (rs_d - {1'b0, dvs_r}) : rs_d;

    // square root step
    rs_s  = {rem_r, num_r[46:45]};
    trial = {2'b00, quot_r[22:0], 2'b01};
    ge_s  = rs_s >= trial;
    rd_s  = ge_s ? (rs_s - trial) : rs_s;
    root_rnd = {1'b0, quot_r[22:0]} + 24'(rem_r > {2'b00, quot_r[22:0]});
    rms_sat  = (root_rnd > 24'd65535) ? 16'hFFFF : root_rnd[15:0];

    v_nxt = quot_r[29] ? 30'(31'h4000_0000 - {1'b0, quot_r[29:0]}) : quot_r[29:0];

    mag     = (up_r ^ quad_r[0]) ? h_r : c_r;
    neg_cos = quad_r[1] ^ quad_r[0];

    coef_mag = coef_r[15] ? (17'd0 - {coef_r[15], coef_r}) : {1'b0, coef_r};

    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SQ) begin
      mul_a = {15'd0, coef_mag};
      mul_b = {15'd0, coef_mag};
    end else begin
      unique case (uop.a)
        wcg_pkg::A_V:  mul_a = {2'b00, v_r};
        wcg_pkg::A_X:  mul_a = {2'b00, x_r};
        wcg_pkg::A_X2: mul_a = {2'b00, x2_r};
        wcg_pkg::A_H:  mul_a = {1'b0, h_r};
        wcg_pkg::A_K:  mul_a = ti.kc;
        default:       mul_a = '0;
      endcase
      unique case (uop.b)
        wcg_pkg::B_CONST: mul_b = uop.kc;
        wcg_pkg::B_X:     mul_b = {2'b00, x_r};
        wcg_pkg::B_H:     mul_b = {1'b0, h_r};
        wcg_pkg::B_MAG:   mul_b = {1'b0, mag};
        default:          mul_b = '0;
      endcase
    end

    p_shr = p_r >> uop.sh;
    p_rnd = p_r + 64'h2000_0000;

    acc_mag = acc_r[35] ? 36'(-acc_r) : 36'(acc_r);
    q_sum   = acc_mag + 36'h2_0000;
    q12     = q_sum[35:18];
    if (acc_r[35]) begin
      coef_nxt = (q12 > 18'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, q12}));
    end else begin
      coef_nxt = (q12 > 18'd32767) ? 16'sd32767 : $signed(q12[15:0]);
    end

    out_free = !out_valid_r || out_word.ready;
  end

  assign in_word.ready  = (state_r == S_IDLE);
  assign out_word.valid = out_valid_r;
  assign out_word.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      type_r       <= wcg_pkg::RST_TYPE;
      length_r     <= wcg_pkg::RST_LENGTH;
      next_index_r <= '0;
      sum_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          wcg_pkg::REG_TYPE:   type_r   <= cfg_wdata[wcg_pkg::TYPE_W-1:0];
          wcg_pkg::REG_LENGTH: length_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_word.ready && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_word.valid) begin
            n_r     <= n_start;
            len_r   <= len_clamp;
            d1_r    <= wcg_pkg::IDX_W'(len_clamp - 13'd1);
            acc_r   <= $signed({4'd0, wcg_pkg::base_q30(type_r)});
            term_r  <= '0;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          rem_r  <= '0;
          quot_r <= '0;
          cnt_r  <= 6'd47;
          if (type_r == wcg_pkg::WT_BARTLETT) begin
            num_r   <= bart_num;
            dvs_r   <= {1'b0, d1_r};
            phase_r <= PH_BART;
            state_r <= S_DIV;
          end else if (term_r < wcg_pkg::term_count(type_r)) begin
            num_r   <= cos_num;
            dvs_r   <= cos_dvs;
            phase_r <= PH_COS;
            state_r <= S_DIV;
          end else begin
            state_r <= S_ROUND;
          end
        end
        S_DIV: begin
          if (cnt_r != '0) begin
            rem_r  <= {12'd0, rd_d[12:0]};
            quot_r <= {quot_r[45:0], ge_d};
            num_r  <= {num_r[45:0], 1'b0};
            cnt_r  <= cnt_r - 6'd1;
          end else begin
            unique case (phase_r)
              PH_COS: begin
                quad_r  <= quot_r[31:30];
                up_r    <= quot_r[29];
                v_r     <= v_nxt;
                step_r  <= '0;
                state_r <= S_MUL;
              end
              PH_BART: begin
                acc_r   <= $signed({5'd0, quot_r[30:0]});
                state_r <= S_ROUND;
              end
              default: begin
                num_r   <= {quot_r[45:0], 1'b0};
                quot_r  <= '0;
                rem_r   <= '0;
                cnt_r   <= 6'd23;
                state_r <= S_SQRT;
              end
            endcase
          end
        end
        S_SQRT: begin
          if (cnt_r != '0) begin
            rem_r  <= rd_s[24:0];
            quot_r <= {quot_r[45:0], ge_s};
            num_r  <= {num_r[44:0], 2'b00};
            cnt_r  <= cnt_r - 6'd1;
          end else begin
            rms_r   <= rms_sat;
            state_r <= S_DONE;
          end
        end
        S_MUL: begin
          p_r     <= mul_a * mul_b;
          state_r <= S_WB;
        end
        S_WB: begin
          unique case (uop.wb)
            wcg_pkg::WB_X:    x_r  <= p_r[60:31];
            wcg_pkg::WB_X2:   x2_r <= p_r[59:30];
            wcg_pkg::WB_HSUB: h_r  <= wcg_pkg::Q30_ONE[30:0] - p_shr[30:0];
            wcg_pkg::WB_H:    h_r  <= p_r[60:30];
            wcg_pkg::WB_C:    c_r  <= wcg_pkg::Q30_ONE[30:0] - p_r[61:31];
            wcg_pkg::WB_S:    h_r  <= p_r[60:30];
            wcg_pkg::WB_ACC: begin
              if (ti.neg ^ neg_cos) acc_r <= acc_r - $signed({2'b00, p_rnd[63:30]});
              else                  acc_r <= acc_r + $signed({2'b00, p_rnd[63:30]});
            end
            default: ;
          endcase
          if (step_r == wcg_pkg::UOP_LAST) begin
            term_r  <= term_r + 3'd1;
            state_r <= S_SETUP;
          end else begin
            step_r  <= step_r + 5'd1;
            state_r <= S_MUL;
          end
        end
        S_ROUND: begin
          coef_r  <= coef_nxt;
          state_r <= S_SQ;
        end
        S_SQ: begin
          p_r     <= mul_a * mul_b;
          state_r <= S_SUM;
        end
        S_SUM: begin
          sum_r  <= sum_nxt;
          last_r <= (n_r == d1_r);
          if (n_r == d1_r) begin
            num_r   <= rms_num;
            dvs_r   <= len_r;
            rem_r   <= '0;
            quot_r  <= '0;
            cnt_r   <= 6'd47;
            phase_r <= PH_RMS;
            state_r <= S_DIV;
          end else begin
            rms_r   <= '0;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r   <= '{coefficient: coef_r, sample_index: n_r,
                              last: last_r, rms_power: rms_r};
            out_valid_r  <= 1'b1;
            next_index_r <= last_r ? '0 : n_r + 12'd1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NXT(a_busy_after_accept, in_word.valid && in_word.ready, !in_word.ready, "word taken while busy")
  `ASSERT_IMP(a_rms_only_last, out_word.valid && !out_word.data.last, out_word.data.rms_power == 16'd0, "rms on non-last word")
  `ASSERT_IMP(a_step_range, state_r == S_MUL || state_r == S_WB, step_r <= wcg_pkg::UOP_LAST, "program step out of range")
  `ASSERT_IMP(a_div_divisor, state_r == S_DIV, dvs_r != '0, "zero divisor")

endmodule
